FILE: rtl/bwla_pkg.sv
// Shared types and constants for the bounded-wait lock arbiter.
// Holds field widths, result status codes and the controller/datapath structs.
// No dependencies.
package bwla_pkg;

  localparam int MAX_REQ_DEFAULT = 16;

  localparam int ID_W     = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 3;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HANDOFF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd4;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Datapath operations issued by the controller.
  localparam logic [1:0] DP_NOP  = 2'd0;
  localparam logic [1:0] DP_LOAD = 2'd1;
  localparam logic [1:0] DP_EVAL = 2'd2;
  localparam logic [1:0] DP_SCAN = 2'd3;

  typedef struct packed {
    logic [1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic rel_ok;
    logic scan_done;
  } dp_stat_t;

endpackage

FILE: rtl/bwla_if.sv
// Handshake channel interfaces for the lock arbiter: requests, results and
// configuration writes. Depends on bwla_pkg.
interface bwla_req_if;
  import bwla_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [ID_W-1:0] requester_id;
  modport source (output valid, req_type, requester_id, input ready);
  modport sink   (input valid, req_type, requester_id, output ready);
endinterface

interface bwla_rsp_if;
  import bwla_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                grant_valid;
  logic [ID_W-1:0]     grant_id;
  modport source (output valid, status, grant_valid, grant_id, input ready);
  modport sink   (input valid, status, grant_valid, grant_id, output ready);
endinterface

interface bwla_cfg_if;
  import bwla_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/bwla_ctrl.sv
// Controller state machine for the lock arbiter.
// Sequences load, evaluate and round-robin scan in the datapath. Depends on bwla_pkg.
module bwla_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwla_pkg::dp_stat_t stat,
  output bwla_pkg::dp_cmd_t  cmd
);
  import bwla_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // Evaluation commits state and result together, so it waits for a free slot.
        if (stat.slot_free) begin
          cmd.op    = DP_EVAL;
          state_nxt = stat.rel_ok ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.slot_free) begin
          cmd.op = DP_SCAN;
          if (stat.scan_done) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/bwla_dp.sv
// Datapath for the lock arbiter: lock state, waiting flags, scan pointer,
// requester count register and result register. Depends on bwla_pkg and bwla_if.
module bwla_dp #(
  parameter int MAX_REQUESTERS = bwla_pkg::MAX_REQ_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_req_type,
  input  logic [bwla_pkg::ID_W-1:0] in_requester_id,
  bwla_cfg_if.sink            cfg_ch,
  bwla_rsp_if.source          out_ch,
  input  bwla_pkg::dp_cmd_t   cmd,
  output bwla_pkg::dp_stat_t  stat
);
  import bwla_pkg::*;

  localparam int IW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int CW = $clog2(MAX_REQUESTERS + 1);
  localparam int SW = (CW > CNT_W) ? CW : CNT_W;

  logic [CNT_W-1:0]          cnt_r;
  logic                      type_r;
  logic [ID_W-1:0]           id_r;
  logic [MAX_REQUESTERS-1:0] flags_r, flags_nxt;
  logic                      lock_r, lock_nxt;
  logic [ID_W-1:0]           owner_r, owner_nxt;
  logic [IW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             steps_r, steps_nxt;
  logic                      ov_r, ov_nxt;
  logic [STATUS_W-1:0]       ost_r, ost_nxt;
  logic                      ogv_r, ogv_nxt;
  logic [ID_W-1:0]           ogid_r, ogid_nxt;

  logic [SW-1:0] cnt_ext, n_ext, id_ext, id_p1, j_p1;
  logic [IW-1:0] idx, j_first, j_next;
  logic          bad, owner_match, is_waiting, emit;
  logic          scan_end, scan_hit;

  assign cfg_ch.ready = 1'b1;

  // Effective count is the register saturated into 1..MAX_REQUESTERS.
  always_comb begin
    cnt_ext = SW'(cnt_r);
    if (cnt_ext == '0)                        n_ext = SW'(1);
    else if (cnt_ext > SW'(MAX_REQUESTERS))   n_ext = SW'(MAX_REQUESTERS);
    else                                      n_ext = cnt_ext;
  end

  assign id_ext      = SW'(id_r);
  assign bad         = (id_ext >= n_ext);
  assign idx         = IW'(id_r);
  assign owner_match = lock_r && (owner_r == id_r);
  assign is_waiting  = flags_r[idx];

  assign id_p1   = id_ext + SW'(1);
  assign j_first = (id_p1 == n_ext) ? '0 : IW'(id_p1);
  assign j_p1    = SW'(j_r) + SW'(1);
  assign j_next  = (j_p1 == n_ext) ? '0 : IW'(j_p1);

  assign scan_end = (SW'(steps_r) >= n_ext);
  assign scan_hit = flags_r[j_r];

  assign stat.slot_free = !ov_r || out_ch.ready;
  assign stat.rel_ok    = !bad && (type_r == REQ_RELEASE) && owner_match;
  assign stat.scan_done = scan_end || scan_hit;

  always_comb begin
    flags_nxt = flags_r;
    lock_nxt  = lock_r;
    owner_nxt = owner_r;
    j_nxt     = j_r;
    steps_nxt = steps_r;
    emit      = 1'b0;
    ost_nxt   = ost_r;
    ogv_nxt   = ogv_r;
    ogid_nxt  = ogid_r;
    unique case (cmd.op)
      DP_EVAL: begin
        priority if (bad) begin
          emit = 1'b1; ost_nxt = ST_ERROR; ogv_nxt = 1'b0; ogid_nxt = '0;
        end else if (type_r == REQ_ACQUIRE) begin
          emit = 1'b1;
          priority if (owner_match || is_waiting) begin
            ost_nxt = ST_ERROR; ogv_nxt = 1'b0; ogid_nxt = '0;
          end else if (!lock_r) begin
            lock_nxt  = 1'b1;
            owner_nxt = id_r;
            ost_nxt = ST_GRANTED; ogv_nxt = 1'b1; ogid_nxt = id_r;
          end else begin
            flags_nxt[idx] = 1'b1;
            ost_nxt = ST_QUEUED; ogv_nxt = 1'b0; ogid_nxt = '0;
          end
        end else if (!owner_match) begin
          emit = 1'b1; ost_nxt = ST_ERROR; ogv_nxt = 1'b0; ogid_nxt = '0;
        end else begin
          j_nxt     = j_first;
          steps_nxt = CW'(1);
        end
      end
      DP_SCAN: begin
        // One requester per cycle while the result slot is free, starting after the owner.
        priority if (scan_end) begin
          emit     = 1'b1;
          lock_nxt = 1'b0;
          ost_nxt = ST_FREED; ogv_nxt = 1'b0; ogid_nxt = '0;
        end else if (scan_hit) begin
          emit          = 1'b1;
          flags_nxt[j_r] = 1'b0;
          owner_nxt     = ID_W'(j_r);
          ost_nxt = ST_HANDOFF; ogv_nxt = 1'b1; ogid_nxt = ID_W'(j_r);
        end else begin
          j_nxt     = j_next;
          steps_nxt = steps_r + CW'(1);
        end
      end
      default: ;
    endcase
    ov_nxt = emit || (ov_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CNT_RESET;
      flags_r <= '0;
      lock_r  <= 1'b0;
      owner_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) cnt_r <= cfg_ch.data;
      flags_r <= flags_nxt;
      lock_r  <= lock_nxt;
      owner_r <= owner_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      type_r <= in_req_type;
      id_r   <= in_requester_id;
    end
    j_r     <= j_nxt;
    steps_r <= steps_nxt;
    ost_r   <= ost_nxt;
    ogv_r   <= ogv_nxt;
    ogid_r  <= ogid_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.grant_valid = ogv_r;
  assign out_ch.grant_id    = ogid_r;

endmodule

FILE: rtl/bounded_wait_lock_arbiter_top.sv
// Bounded-wait lock arbiter: one lock shared by up to MAX_REQUESTERS requesters.
// An acquire or a faulty request is loaded on acceptance and its result is
// registered when evaluated; a release by the owner adds a round-robin scan of
// the waiting flags, one requester per cycle while the result slot is free.
// One request is in flight at a time; the result register lets the next request
// be accepted while the previous result waits. Depends on bwla_pkg and bwla_if.
module bounded_wait_lock_arbiter_top #(
  parameter int MAX_REQUESTERS = bwla_pkg::MAX_REQ_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  bwla_req_if.sink   in_ch,
  bwla_rsp_if.source out_ch,
  bwla_cfg_if.sink   cfg_ch
);
  import bwla_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bwla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bwla_dp #(
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_ch.req_type),
    .in_requester_id (in_ch.requester_id),
    .cfg_ch          (cfg_ch),
    .out_ch          (out_ch),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

FILE: dv/bounded_wait_lock_arbiter_top_tb.sv
// Self-checking testbench for the bounded-wait lock arbiter top level.
// It predicts every grant, queue, free, hand-off and error in a small scoreboard class.
// Depends on rtl/bwla_pkg.sv, rtl/bwla_if.sv and rtl/bounded_wait_lock_arbiter_top.sv.
`timescale 1ns / 1ps

module bounded_wait_lock_arbiter_top_tb;
  import bwla_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 50;
  localparam int PHASES      = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    logic [ID_W-1:0]     grant_id;
  } lock_result_t;

  // Tracks the lock state and holds the results that the block still owes.
  class lock_scoreboard;
    bit                  waiting [MAX_REQ_DEFAULT];
    bit                  held;
    logic [ID_W-1:0]     owner;
    logic [CNT_W-1:0]    count;
    lock_result_t        pending_results[$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    int unsigned         status_hits [5];

    function new();
      held  = 1'b0;
      owner = '0;
      count = CNT_RESET;
    endfunction

    function int unsigned active_count();
      if (count == 0) return 1;
      if (count > MAX_REQ_DEFAULT) return MAX_REQ_DEFAULT;
      return count;
    endfunction

    function void note_request(logic rt, logic [ID_W-1:0] id);
      lock_result_t r;
      int unsigned  n;
      int unsigned  j;
      n = active_count();
      r = '{status: ST_ERROR, grant_valid: 1'b0, grant_id: '0};
      if (id < n) begin
        if (rt == REQ_ACQUIRE) begin
          if (!((held && owner == id) || waiting[id])) begin
            if (!held) begin
              held = 1'b1;
              owner = id;
              r = '{status: ST_GRANTED, grant_valid: 1'b1, grant_id: id};
            end else begin
              waiting[id] = 1'b1;
              r.status = ST_QUEUED;
            end
          end
        end else if (held && owner == id) begin
          // Round-robin scan starts at the owner's successor and wraps at the count.
          held = 1'b0;
          r.status = ST_FREED;
          j = (id + 1) % n;
          for (int unsigned s = 1; s < n; s++) begin
            if (waiting[j]) begin
              waiting[j] = 1'b0;
              held = 1'b1;
              owner = ID_W'(j);
              r = '{status: ST_HANDOFF, grant_valid: 1'b1, grant_id: ID_W'(j)};
              break;
            end
            j = (j + 1) % n;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time, got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (want.status < 5) status_hits[want.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.grant_valid !== want.grant_valid) begin
        $display("%0t: grant_valid mismatch, expected %0d, got %0d",
                 $time, want.grant_valid, got.grant_valid);
        mismatches++;
      end
      if (got.grant_id !== want.grant_id) begin
        $display("%0t: grant_id mismatch, expected %0d, got %0d",
                 $time, want.grant_id, got.grant_id);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int unsigned cycle_count;
  int unsigned items_sent;

  bwla_req_if req_ch();
  bwla_rsp_if rsp_ch();
  bwla_cfg_if cfg_ch();

  lock_scoreboard lock_sb = new();

  bounded_wait_lock_arbiter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next ready value.
  always @(posedge clk) begin
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      lock_sb.check_result('{status: rsp_ch.status, grant_valid: rsp_ch.grant_valid,
                             grant_id: rsp_ch.grant_id});
    rsp_ch.ready <= !(idle_on && $urandom_range(99) < 12);
  end

  // Valid is left high after acceptance so back-to-back transactions need no toggle.
  task automatic send_request(input logic rt, input logic [ID_W-1:0] id);
    while (idle_on && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rt;
    req_ch.requester_id <= id;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    lock_sb.note_request(rt, id);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (lock_sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid  <= 1'b0;
    lock_sb.count = value;
  endtask

  initial begin
    int unsigned      phase_counts [PHASES] = '{16, 5, 31, 2, 0, 1, 12, 16};
    int unsigned      n;
    int unsigned      sel;
    logic             rt;
    logic [ID_W-1:0]  id;

    idle_on             = 1'b1;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_ACQUIRE;
    req_ch.requester_id <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: errors, grants, queuing, hand-off with wrap and a lowered count.
    send_request(REQ_RELEASE, 4'd0);
    send_request(REQ_ACQUIRE, 4'd0);
    send_request(REQ_ACQUIRE, 4'd0);
    send_request(REQ_ACQUIRE, 4'd15);
    send_request(REQ_ACQUIRE, 4'd15);
    send_request(REQ_ACQUIRE, 4'd7);
    send_request(REQ_RELEASE, 4'd7);
    send_request(REQ_RELEASE, 4'd0);
    send_request(REQ_RELEASE, 4'd7);
    send_request(REQ_ACQUIRE, 4'd3);
    send_request(REQ_RELEASE, 4'd15);
    send_request(REQ_ACQUIRE, 4'd12);
    write_count(5'd8);
    send_request(REQ_ACQUIRE, 4'd9);
    send_request(REQ_RELEASE, 4'd3);
    send_request(REQ_ACQUIRE, 4'd3);
    write_count(5'd16);
    send_request(REQ_ACQUIRE, 4'd12);
    send_request(REQ_RELEASE, 4'd3);
    write_count(5'd4);
    send_request(REQ_RELEASE, 4'd12);
    write_count(5'd16);
    send_request(REQ_RELEASE, 4'd12);

    // Random part: mostly legal traffic so waiters pile up and hand-offs happen.
    for (int p = 0; p < PHASES; p++) begin
      write_count(CNT_W'(phase_counts[p]));
      idle_on = (p != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) wait_drained();
        n   = lock_sb.active_count();
        sel = $urandom_range(99);
        if (sel < 45) begin
          rt = REQ_ACQUIRE;
          id = ID_W'($urandom_range(n - 1));
        end else if (sel < 80 && lock_sb.held) begin
          rt = REQ_RELEASE;
          id = lock_sb.owner;
        end else if (sel < 90) begin
          rt = REQ_RELEASE;
          id = ID_W'($urandom_range(n - 1));
        end else begin
          rt = 1'($urandom_range(1));
          id = ID_W'($urandom_range(15));
        end
        send_request(rt, id);
      end
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (2 * MAX_REQ_DEFAULT + 8) @(posedge clk);

    $display("Covered %0d requests over %0d requester counts, %0d results checked.",
             items_sent, PHASES, lock_sb.results_seen);
    $display("Grants %0d, queued %0d, frees %0d, hand-offs %0d, errors %0d.",
             lock_sb.status_hits[ST_GRANTED], lock_sb.status_hits[ST_QUEUED],
             lock_sb.status_hits[ST_FREED], lock_sb.status_hits[ST_HANDOFF],
             lock_sb.status_hits[ST_ERROR]);
    if (lock_sb.pending_results.size() != 0)
      $display("%0t: %0d expected results never arrived",
               $time, lock_sb.pending_results.size());
    if (lock_sb.mismatches == 0 && lock_sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
